FILE: rtl/cspat_pkg.sv
// shared types and constants for the call site page accounting table
package cspat_pkg;

  // table geometry
  localparam int SITES   = 64;
  localparam int SLOT_W  = $clog2(SITES);
  localparam int CNT_W   = $clog2(SITES + 1);
  localparam int HASH_SH = 4;

  // request commands
  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_SNAP  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  // one input request
  typedef struct packed {
    cmd_t        command;
    logic [63:0] caller_pc;
    logic [31:0] page_count;
    logic [15:0] free_slot;
    logic [15:0] max_entries;
  } req_t;

  // one result
  typedef struct packed {
    logic [5:0]  slot_index;
    logic [63:0] site_address;
    logic [63:0] alloc_total;
    logic [63:0] free_total;
    logic        entry_valid;
    logic        last;
  } rsp_t;

  // one table entry
  typedef struct packed {
    logic [63:0] addr;
    logic [63:0] alloc;
    logic [63:0] free;
  } entry_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROBE_RD,
    ST_PROBE_CK,
    ST_UPD_RD,
    ST_UPD_WR,
    ST_SNAP_RD,
    ST_SNAP_CK,
    ST_SNAP_FIN
  } state_t;

  // source of the output register
  typedef enum logic [1:0] {
    OSEL_NONE,
    OSEL_UPD,
    OSEL_PEND,
    OSEL_MARK
  } out_sel_t;

  // controller to datapath commands
  typedef struct packed {
    logic     load_req;
    logic     mem_rd;
    logic     adv;
    logic     to_slot0;
    logic     set_claim;
    logic     mem_wr;
    logic     pend_take;
    out_sel_t out_sel;
    logic     out_last;
  } ctl_t;

  // datapath to controller status
  typedef struct packed {
    cmd_t command;
    logic pc_zero;
    logic limit_zero;
    logic slot_zero;
    logic probe_done;
    logic hit;
    logic nonempty;
    logic scan_end;
    logic limit_hit;
    logic pend_v;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/call_site_page_accounting_table.sv
// top level: per-caller page counter table with hashed linear probing
// free: reads, updates and returns the named slot (slot 0 if out of range); alloc: probes
// from the hashed home slot, skipping slot 0, to the caller's entry or an empty one, else
// (and for caller 0) uses slot 0; snapshot: nonempty slots up to max_entries, pausing on
// stalled results; one request at a time, the next taken once the last result is loaded
// reset (synchronous, active high) clears all valid bits at once, so every slot reads zero
module call_site_page_accounting_table (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  cspat_pkg::req_t req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output cspat_pkg::rsp_t rsp
);
  import cspat_pkg::*;

  ctl_t ctl;
  sts_t sts;

  // sequencer
  cspat_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  // table and result path
  cspat_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .ctl       (ctl),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

FILE: rtl/cspat_dp.sv
// datapath: table memory, probe pointers, pending snapshot entry, output register
module cspat_dp (
  input  logic            clk,
  input  logic            rst,
  input  cspat_pkg::req_t req,
  input  cspat_pkg::ctl_t ctl,
  output cspat_pkg::sts_t sts,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output cspat_pkg::rsp_t rsp
);
  import cspat_pkg::*;

  req_t              cur;
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] probe;
  logic [CNT_W-1:0]  count;
  logic              claim;
  entry_t            mem [SITES];
  logic [SITES-1:0]  vld;
  entry_t            rd_data;
  entry_t            pend;
  logic [SLOT_W-1:0] pend_slot;
  logic              pend_v;
  entry_t            upd;
  logic [SLOT_W-1:0] home;
  logic [SLOT_W-1:0] start_slot;
  logic [SLOT_W-1:0] slot_next;
  logic [63:0]       pages;
  logic              out_free;

  // hash and starting slot of a new request
  assign home  = SLOT_W'((req.caller_pc >> HASH_SH) % SITES);
  always_comb begin
    case (req.command)
      CMD_ALLOC: start_slot = (req.caller_pc == 64'd0) ? '0 : home;
      CMD_FREE:  start_slot = (req.free_slot >= 16'(SITES)) ? '0
                                                            : SLOT_W'(req.free_slot);
      default:   start_slot = '0;
    endcase
  end

  // linear probe step with wrap
  assign slot_next = (slot == SLOT_W'(SITES - 1)) ? '0 : slot + 1'b1;

  // request, pointer and pending registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v <= 1'b0;
      claim  <= 1'b0;
    end else begin
      if (ctl.load_req) begin
        cur    <= req;
        slot   <= start_slot;
        probe  <= '0;
        count  <= '0;
        claim  <= 1'b0;
        pend_v <= 1'b0;
      end
      if (ctl.adv) begin
        slot  <= slot_next;
        probe <= probe + 1'b1;
      end
      if (ctl.to_slot0) begin
        slot <= '0;
      end
      if (ctl.set_claim) begin
        claim <= 1'b1;
      end
      if (ctl.pend_take) begin
        pend      <= rd_data;
        pend_slot <= slot;
        pend_v    <= 1'b1;
        count     <= count + 1'b1;
      end
    end
  end

  // valid bits: an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ctl.mem_wr) begin
      vld[slot] <= 1'b1;
    end
  end

  // table memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (ctl.mem_wr) begin
      mem[slot] <= upd;
    end
    if (ctl.mem_rd) begin
      rd_data <= vld[slot] ? mem[slot] : '0;
    end
  end

  // counter update for alloc or free
  assign pages = {32'd0, cur.page_count};
  always_comb begin
    upd.addr  = claim ? cur.caller_pc : rd_data.addr;
    upd.alloc = rd_data.alloc + ((cur.command == CMD_ALLOC) ? pages : 64'd0);
    upd.free  = rd_data.free + ((cur.command == CMD_FREE) ? pages : 64'd0);
  end

  // output register
  assign out_free = !rsp_valid || !rsp_stall;
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.out_sel != OSEL_NONE) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.out_sel)
      OSEL_UPD: begin
        rsp <= '{slot_index: 6'(slot), site_address: upd.addr, alloc_total: upd.alloc,
                 free_total: upd.free, entry_valid: 1'b1, last: 1'b1};
      end
      OSEL_PEND: begin
        rsp <= '{slot_index: 6'(pend_slot), site_address: pend.addr,
                 alloc_total: pend.alloc, free_total: pend.free,
                 entry_valid: 1'b1, last: ctl.out_last};
      end
      OSEL_MARK: begin
        rsp <= '{slot_index: 6'd0, site_address: 64'd0, alloc_total: 64'd0,
                 free_total: 64'd0, entry_valid: 1'b0, last: 1'b1};
      end
      default: begin
      end
    endcase
  end

  // status to the controller
  always_comb begin
    sts.command    = req.command;
    sts.pc_zero    = (req.caller_pc == 64'd0);
    sts.limit_zero = (req.max_entries == 16'd0);
    sts.slot_zero  = (slot == '0);
    sts.probe_done = (probe == SLOT_W'(SITES - 1));
    sts.hit        = (rd_data.addr == cur.caller_pc) || (rd_data.addr == 64'd0);
    sts.nonempty   = (rd_data.addr != 64'd0) || (rd_data.alloc != 64'd0) ||
                     (rd_data.free != 64'd0);
    sts.scan_end   = (slot == SLOT_W'(SITES - 1));
    sts.limit_hit  = ((16'(count) + 16'd1) == cur.max_entries);
    sts.pend_v     = pend_v;
    sts.out_free   = out_free;
  end

endmodule

FILE: rtl/cspat_ctrl.sv
// controller: sequences probe, update and snapshot scan
module cspat_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  cspat_pkg::sts_t sts,
  output cspat_pkg::ctl_t ctl
);
  import cspat_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req_stall = (state != ST_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    ctl        = '0;
    ctl.out_sel = OSEL_NONE;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          ctl.load_req = 1'b1;
          case (sts.command)
            CMD_ALLOC: state_next = sts.pc_zero ? ST_UPD_RD : ST_PROBE_RD;
            CMD_FREE:  state_next = ST_UPD_RD;
            CMD_SNAP:  state_next = sts.limit_zero ? ST_SNAP_FIN : ST_SNAP_RD;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      // probe: slot 0 is skipped without a read
      ST_PROBE_RD: begin
        if (sts.slot_zero) begin
          if (sts.probe_done) begin
            ctl.to_slot0 = 1'b1;
            state_next   = ST_UPD_RD;
          end else begin
            ctl.adv = 1'b1;
          end
        end else begin
          ctl.mem_rd = 1'b1;
          state_next = ST_PROBE_CK;
        end
      end
      ST_PROBE_CK: begin
        if (sts.hit) begin
          ctl.set_claim = 1'b1;
          state_next    = ST_UPD_WR;
        end else if (sts.probe_done) begin
          ctl.to_slot0 = 1'b1;
          state_next   = ST_UPD_RD;
        end else begin
          ctl.adv    = 1'b1;
          state_next = ST_PROBE_RD;
        end
      end
      ST_UPD_RD: begin
        ctl.mem_rd = 1'b1;
        state_next = ST_UPD_WR;
      end
      // write back and present the result together
      ST_UPD_WR: begin
        if (sts.out_free) begin
          ctl.mem_wr   = 1'b1;
          ctl.out_sel  = OSEL_UPD;
          ctl.out_last = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_SNAP_RD: begin
        ctl.mem_rd = 1'b1;
        state_next = ST_SNAP_CK;
      end
      // a found entry is held until the next one is found so the final one can carry last
      ST_SNAP_CK: begin
        if (!sts.nonempty) begin
          if (sts.scan_end) begin
            state_next = ST_SNAP_FIN;
          end else begin
            ctl.adv    = 1'b1;
            state_next = ST_SNAP_RD;
          end
        end else if (!sts.pend_v || sts.out_free) begin
          if (sts.pend_v) begin
            ctl.out_sel = OSEL_PEND;
          end
          ctl.pend_take = 1'b1;
          if (sts.limit_hit || sts.scan_end) begin
            state_next = ST_SNAP_FIN;
          end else begin
            ctl.adv    = 1'b1;
            state_next = ST_SNAP_RD;
          end
        end
      end
      ST_SNAP_FIN: begin
        if (sts.out_free) begin
          ctl.out_sel  = sts.pend_v ? OSEL_PEND : OSEL_MARK;
          ctl.out_last = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/cspat_chk.sv
// port-level checks for the page accounting table, bound to the top level
module cspat_chk (
  input logic            clk,
  input logic            rst,
  input logic            req_valid,
  input logic            req_stall,
  input cspat_pkg::req_t req,
  input logic            rsp_valid,
  input logic            rsp_stall,
  input cspat_pkg::rsp_t rsp
);
  import cspat_pkg::*;

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed");

  // one request at a time: a working request blocks the next
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && req.command != CMD_NOP |=> req_stall)
    else $error("request accepted while busy");

  // empty snapshot marker is all zero and final
  a_marker: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.entry_valid |-> rsp.last && rsp.slot_index == 6'd0 &&
      rsp.site_address == 64'd0 && rsp.alloc_total == 64'd0 &&
      rsp.free_total == 64'd0)
    else $error("bad empty marker");

  // the catch-all slot never holds a caller address
  a_slot0: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.entry_valid && rsp.slot_index == 6'd0 |-> rsp.site_address == 64'd0)
    else $error("slot 0 holds an address");

endmodule

bind call_site_page_accounting_table cspat_chk u_chk (.*);
